// File: design/bline_pkg.sv
// bline_pkg: shared types, constants and the colour map for the line pixel generator
// used by bline_ctrl, bline_dp and bresenham_line_pixel_gen; no dependencies
package bline_pkg;

  localparam int COORD_W   = 6;
  localparam int COLOR_W   = 3;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;
  localparam int INDEX_W   = 12;
  localparam int WORD_W    = 32;
  localparam int ERR_W     = COORD_W + 3;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 56;

  localparam int DEF_MAX_WIDTH  = 64;
  localparam int DEF_MAX_HEIGHT = 64;

  localparam logic [CFG_W-1:0] RESET_WIDTH  = 7'd64;
  localparam logic [CFG_W-1:0] RESET_HEIGHT = 7'd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CANVAS_WIDTH  = 1'b0,
    REG_CANVAS_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_DIFF = 2'd1,
    ST_INIT = 2'd2,
    ST_RUN  = 2'd3
  } state_t;

  typedef struct packed {
    logic load;
    logic diff;
    logic init;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic last;
  } status_t;

  // byte layout GG BB 00 RR
  function automatic logic [WORD_W-1:0] color_lookup(input logic [COLOR_W-1:0] idx);
    logic [WORD_W-1:0] w;
    case (idx)
      3'd0:    w = 32'h0000_0000;
      3'd1:    w = 32'h0000_00FF;
      3'd2:    w = 32'h00FF_0000;
      3'd3:    w = 32'hFF00_0000;
      3'd4:    w = 32'hFFFF_0000;
      3'd5:    w = 32'hFF00_00FF;
      3'd6:    w = 32'h00FF_00FF;
      3'd7:    w = 32'hC0C0_00FF;
      default: w = 32'h0000_0000;
    endcase
    return w;
  endfunction

endpackage

// File: design/bline_ctrl.sv
// bline_ctrl: sequencer for the line walk and owner of the output valid flag
// depends on bline_pkg; drives bline_dp through cmd_t and reads status_t
module bline_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output bline_pkg::cmd_t      cmd,
  input  bline_pkg::status_t   status
);

  bline_pkg::state_t state;
  bline_pkg::state_t state_next;
  logic              out_valid_next;
  logic              emit;

  assign emit = (state == bline_pkg::ST_RUN) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bline_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      bline_pkg::ST_IDLE: begin
        if (in_valid) state_next = bline_pkg::ST_DIFF;
      end
      bline_pkg::ST_DIFF: state_next = bline_pkg::ST_INIT;
      bline_pkg::ST_INIT: state_next = bline_pkg::ST_RUN;
      bline_pkg::ST_RUN: begin
        if (emit && status.last) state_next = bline_pkg::ST_IDLE;
      end
      default: state_next = bline_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == bline_pkg::ST_IDLE);
    cmd.load  = (state == bline_pkg::ST_IDLE) && in_valid;
    cmd.diff  = (state == bline_pkg::ST_DIFF);
    cmd.init  = (state == bline_pkg::ST_INIT);
    cmd.step  = emit;
    // output register holds a pixel until the receiver takes it
    if (emit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

// File: design/bline_dp.sv
// bline_dp: canvas registers, endpoint ordering, error-term walk and pixel output register
// depends on bline_pkg; controlled by bline_ctrl
module bline_dp #(
  parameter int MAX_WIDTH  = bline_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bline_pkg::DEF_MAX_HEIGHT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [bline_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bline_pkg::CFG_W-1:0]        cfg_data,
  input  logic [bline_pkg::COORD_W-1:0]      start_x,
  input  logic [bline_pkg::COORD_W-1:0]      start_y,
  input  logic [bline_pkg::COORD_W-1:0]      end_x,
  input  logic [bline_pkg::COORD_W-1:0]      end_y,
  input  logic [bline_pkg::COLOR_W-1:0]      color_index,
  input  bline_pkg::cmd_t                    cmd,
  output bline_pkg::status_t                 status,
  output logic [bline_pkg::COORD_W-1:0]      pixel_x,
  output logic [bline_pkg::COORD_W-1:0]      pixel_y,
  output logic                               inside_res,
  output logic [bline_pkg::INDEX_W-1:0]      map_index,
  output logic [bline_pkg::WORD_W-1:0]       color_word,
  output logic                               last
);

  localparam int CW = bline_pkg::CFG_W;
  localparam int XW = bline_pkg::COORD_W;
  localparam int EW = bline_pkg::ERR_W;
  localparam logic [CW-1:0] W_CAP = (MAX_WIDTH  > 127) ? 7'd127 : CW'(MAX_WIDTH);
  localparam logic [CW-1:0] H_CAP = (MAX_HEIGHT > 127) ? 7'd127 : CW'(MAX_HEIGHT);

  logic [CW-1:0] canvas_width;
  logic [CW-1:0] canvas_height;

  logic [XW-1:0]                   x0, y0, x1, y1;
  logic [bline_pkg::COLOR_W-1:0]   color_sel;
  logic [XW-1:0]                   dx, dy;
  logic                            y_down;
  logic                            steep;
  logic [XW-1:0]                   dmaj, dmin;
  logic signed [EW-1:0]            err;
  logic [XW-1:0]                   cnt;
  logic [XW-1:0]                   x, y;

  logic                            swap;
  logic [XW-1:0]                   y_step;
  logic signed [EW-1:0]            two_maj, two_min, err_adj, err_next;
  logic                            minor_step;
  logic [CW-1:0]                   w_eff, h_eff;
  logic                            in_canvas;
  logic [XW+CW-1:0]                row_base;
  logic [XW+CW-1:0]                idx_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width  <= bline_pkg::RESET_WIDTH;
      canvas_height <= bline_pkg::RESET_HEIGHT;
    end else if (cfg_write) begin
      case (bline_pkg::cfg_reg_t'(cfg_index))
        bline_pkg::REG_CANVAS_WIDTH:  canvas_width  <= cfg_data;
        bline_pkg::REG_CANVAS_HEIGHT: canvas_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign swap       = end_x < start_x;
  assign two_maj    = EW'({dmaj, 1'b0});
  assign two_min    = EW'({dmin, 1'b0});
  assign minor_step = (err >= 0);
  assign err_adj    = minor_step ? (err - two_maj) : err;
  assign err_next   = err_adj + two_min;
  assign y_step     = y_down ? (y - XW'(1)) : (y + XW'(1));

  assign w_eff     = (canvas_width  < W_CAP) ? canvas_width  : W_CAP;
  assign h_eff     = (canvas_height < H_CAP) ? canvas_height : H_CAP;
  assign in_canvas = ({1'b0, x} < w_eff) && ({1'b0, y} < h_eff);
  assign row_base  = y * w_eff;
  assign idx_sum   = row_base + (XW+CW)'(x);

  assign status.last = (cnt == '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      // walk always runs left to right
      x0        <= swap ? end_x   : start_x;
      y0        <= swap ? end_y   : start_y;
      x1        <= swap ? start_x : end_x;
      y1        <= swap ? start_y : end_y;
      color_sel <= color_index;
    end
    if (cmd.diff) begin
      dx     <= x1 - x0;
      dy     <= (y1 < y0) ? (y0 - y1) : (y1 - y0);
      y_down <= y1 < y0;
      x      <= x0;
      y      <= y0;
    end
    if (cmd.init) begin
      // equal deltas count as steep
      steep <= dx <= dy;
      dmaj  <= (dx > dy) ? dx : dy;
      dmin  <= (dx > dy) ? dy : dx;
      cnt   <= (dx > dy) ? dx : dy;
      err   <= (dx > dy) ? (EW'({dy, 1'b0}) - EW'(dx)) : (EW'({dx, 1'b0}) - EW'(dy));
    end
    if (cmd.step) begin
      pixel_x    <= x;
      pixel_y    <= y;
      inside_res <= in_canvas;
      map_index  <= in_canvas ? idx_sum[bline_pkg::INDEX_W-1:0] : '0;
      color_word <= bline_pkg::color_lookup(color_sel);
      last       <= status.last;
      err        <= err_next;
      cnt        <= cnt - XW'(1);
      if (steep) begin
        y <= y_step;
        if (minor_step) x <= x + XW'(1);
      end else begin
        x <= x + XW'(1);
        if (minor_step) y <= y_step;
      end
    end
  end

endmodule

// File: design/bresenham_line_pixel_gen.sv
// bresenham_line_pixel_gen: top level of the line pixel generator
// depends on bline_pkg, bline_ctrl and bline_dp
//
// usage: one transfer on the s_ channel is one line request (two endpoints
// and a colour index). the block answers with one m_ transfer per pixel,
// max(|dx|,|dy|)+1 of them (1 to 64), walked left to right; m_tlast marks
// the final pixel and m_tuser says whether the pixel lies on the canvas.
// canvas width and height are written on the cfg_ channel (index 0 width,
// index 1 height) while no line is in flight; cfg_ready is always high.
// sequence: after the request the block steps through its diff and init states
// before the walk starts; it then gives one pixel per cycle from the walk counter
// and error-term adder while m_tready does not stall the output; the next request is
// taken as soon as the last pixel sits in the output register.
// reset: synchronous; clears the sequencer and output valid and sets the
// canvas to 64 by 64. a stalled m_tready holds the output register and
// freezes the walk until the pixel is taken.
module bresenham_line_pixel_gen #(
  parameter int MAX_WIDTH  = bline_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bline_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // start_x[5:0], start_y[11:6], end_x[17:12], end_y[23:18], color_index[26:24], zero pad
  input  logic [bline_pkg::IN_DATA_W-1:0]      s_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // pixel_x[5:0], pixel_y[11:6], map_index[23:12], color_word[55:24]
  output logic [bline_pkg::OUT_DATA_W-1:0]     m_tdata,
  // inside_res[0]
  output logic                                 m_tuser,
  output logic                                 m_tlast,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [bline_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bline_pkg::CFG_W-1:0]          cfg_data
);

  bline_pkg::cmd_t                     cmd;
  bline_pkg::status_t                  status;
  logic [bline_pkg::COORD_W-1:0]       pixel_x;
  logic [bline_pkg::COORD_W-1:0]       pixel_y;
  logic [bline_pkg::INDEX_W-1:0]       map_index;
  logic [bline_pkg::WORD_W-1:0]        color_word;

  assign cfg_ready = 1'b1;
  assign m_tdata   = {color_word, map_index, pixel_y, pixel_x};

  bline_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .cmd       (cmd),
    .status    (status)
  );

  bline_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_valid & cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .start_x     (s_tdata[5:0]),
    .start_y     (s_tdata[11:6]),
    .end_x       (s_tdata[17:12]),
    .end_y       (s_tdata[23:18]),
    .color_index (s_tdata[26:24]),
    .cmd         (cmd),
    .status      (status),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .inside_res  (m_tuser),
    .map_index   (map_index),
    .color_word  (color_word),
    .last        (m_tlast)
  );

endmodule

// File: test/tb_bresenham_line_pixel_gen.sv
// tb_bresenham_line_pixel_gen: self-checking bench for the line pixel generator
// traces each line request with its own bresenham walk and compares every pixel
// depends on bline_pkg and bresenham_line_pixel_gen
module tb_bresenham_line_pixel_gen;
  import bline_pkg::*;

  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int SEGMENTS      = 5;
  localparam int LINES_PER_SEG = 19;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic [COORD_W-1:0] ey;
    logic [COORD_W-1:0] ex;
    logic [COORD_W-1:0] sy;
    logic [COORD_W-1:0] sx;
  } line_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               on_canvas;
    logic [INDEX_W-1:0] idx;
    logic [WORD_W-1:0]  color;
    logic               last;
  } pixel_t;

  class line_scoreboard;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    pixel_t           pixels_due[$];
    int               mismatches;
    int               compared;
    logic [WORD_W-1:0] palette[8];

    function new();
      width_reg  = RESET_WIDTH;
      height_reg = RESET_HEIGHT;
      mismatches = 0;
      compared   = 0;
      palette = '{32'h0000_0000, 32'h0000_00FF, 32'h00FF_0000, 32'hFF00_0000,
                  32'hFFFF_0000, 32'hFF00_00FF, 32'h00FF_00FF, 32'hC0C0_00FF};
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
      if (idx == REG_CANVAS_WIDTH) width_reg = val;
      else height_reg = val;
    endfunction

    function int pending();
      return pixels_due.size();
    endfunction

    // walk the line left to right and queue one pixel per step
    function void note_line(line_t ln);
      int x0, y0, x1, y1, t, dx, dy, sgn, err, x, y, n, total, w, h, ux, uy;
      logic   steep;
      pixel_t p;
      x0 = int'(ln.sx); y0 = int'(ln.sy); x1 = int'(ln.ex); y1 = int'(ln.ey);
      if (x1 < x0) begin
        t = x0; x0 = x1; x1 = t;
        t = y0; y0 = y1; y1 = t;
      end
      dx = x1 - x0;
      dy = y1 - y0;
      sgn = 1;
      if (dy < 0) begin
        dy = -dy;
        sgn = -1;
      end
      w = (width_reg < DEF_MAX_WIDTH) ? int'(width_reg) : DEF_MAX_WIDTH;
      h = (height_reg < DEF_MAX_HEIGHT) ? int'(height_reg) : DEF_MAX_HEIGHT;
      // dx == dy counts as steep
      steep = !(dx > dy);
      total = steep ? dy + 1 : dx + 1;
      err   = steep ? 2 * dx - dy : 2 * dy - dx;
      x = x0;
      y = y0;
      for (n = 0; n < total; n++) begin
        ux = x & 63;
        uy = y & 63;
        p.x         = ux[COORD_W-1:0];
        p.y         = uy[COORD_W-1:0];
        p.on_canvas = (ux < w) && (uy < h);
        p.idx       = p.on_canvas ? INDEX_W'(ux + uy * w) : '0;
        p.color     = palette[ln.color];
        p.last      = (n == total - 1);
        pixels_due.push_back(p);
        if (!steep) begin
          if (err >= 0) begin
            y += sgn;
            err -= 2 * dx;
          end
          x++;
          err += 2 * dy;
        end else begin
          if (err >= 0) begin
            x++;
            err -= 2 * dy;
          end
          y += sgn;
          err += 2 * dx;
        end
      end
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (pixels_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected pixel x=%0d y=%0d in=%0b idx=%0d col=%h last=%0b",
                   got.x, got.y, got.on_canvas, got.idx, got.color, got.last);
        return;
      end
      want = pixels_due.pop_front();
      compared++;
      if (got.x != want.x || got.y != want.y || got.on_canvas != want.on_canvas ||
          got.idx != want.idx || got.color != want.color || got.last != want.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("pixel mismatch %0d: expected x=%0d y=%0d in=%0b idx=%0d col=%h last=%0b",
                   compared, want.x, want.y, want.on_canvas, want.idx, want.color,
                   want.last);
          $display("                 actual   x=%0d y=%0d in=%0b idx=%0d col=%h last=%0b",
                   got.x, got.y, got.on_canvas, got.idx, got.color, got.last);
        end
      end
    endfunction

    function void flag_leftover();
      if (pixels_due.size() != 0) begin
        mismatches++;
        $display("%0d expected pixels never arrived", pixels_due.size());
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;
  logic                  m_tlast;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]      cfg_data;

  line_scoreboard sb = new();
  int send_idle_pct = 21;
  int recv_idle_pct = 62;
  int lines_sent    = 0;
  int reg_writes    = 0;

  bresenham_line_pixel_gen u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(negedge clk) begin
    m_tready = rst ? 1'b0 : ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_pixel('{x: m_tdata[5:0], y: m_tdata[11:6], on_canvas: m_tuser,
                       idx: m_tdata[23:12], color: m_tdata[55:24], last: m_tlast});
  end

  // give up after a long stretch with no transfer on any channel
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  task automatic send_line(line_t ln);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {5'b0, ln.color, ln.ey, ln.ex, ln.sy, ln.sx};
    do @(posedge clk); while (!s_tready);
    sb.note_line(ln);
    lines_sent++;
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    reg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // hold the sender until every queued pixel has come out
  task automatic drain_pixels();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic line_t make_line(int sx, int sy, int ex, int ey, int c);
    line_t ln;
    ln.sx = COORD_W'(sx); ln.sy = COORD_W'(sy);
    ln.ex = COORD_W'(ex); ln.ey = COORD_W'(ey);
    ln.color = COLOR_W'(c);
    return ln;
  endfunction

  function automatic line_t random_line();
    line_t       ln;
    int          ex, ey;
    logic [31:0] r;
    r  = $urandom();
    ln = r[$bits(line_t)-1:0];
    if ($urandom_range(0, 9) < 3) begin
      // short lines near the start point
      ex = int'(ln.sx) + $urandom_range(0, 6) - 3;
      ey = int'(ln.sy) + $urandom_range(0, 6) - 3;
      ln.ex = COORD_W'((ex < 0) ? 0 : (ex > 63) ? 63 : ex);
      ln.ey = COORD_W'((ey < 0) ? 0 : (ey > 63) ? 63 : ey);
    end
    return ln;
  endfunction

  initial begin
    line_t            directed[$];
    logic [CFG_W-1:0] wv, hv;
    int               seg, k;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_CANVAS_WIDTH;
    cfg_data  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // single pixels, axis lines, diagonals, reversed and negative slopes
    directed.push_back(make_line(0, 0, 0, 0, 0));
    directed.push_back(make_line(63, 63, 63, 63, 1));
    directed.push_back(make_line(0, 0, 63, 0, 2));
    directed.push_back(make_line(0, 63, 0, 0, 3));
    directed.push_back(make_line(0, 0, 0, 63, 4));
    directed.push_back(make_line(0, 0, 63, 63, 5));
    directed.push_back(make_line(63, 63, 0, 0, 6));
    directed.push_back(make_line(0, 63, 63, 0, 7));
    directed.push_back(make_line(63, 0, 0, 63, 0));
    directed.push_back(make_line(2, 40, 50, 31, 1));
    directed.push_back(make_line(50, 31, 2, 40, 2));
    directed.push_back(make_line(10, 5, 14, 60, 3));
    directed.push_back(make_line(14, 60, 10, 5, 4));
    directed.push_back(make_line(30, 30, 31, 31, 5));
    directed.push_back(make_line(63, 0, 62, 1, 6));
    directed.push_back(make_line(5, 20, 6, 20, 7));
    directed.push_back(make_line(42, 21, 21, 42, 7));
    foreach (directed[i]) send_line(directed[i]);
    drain_pixels();

    for (seg = 0; seg < SEGMENTS; seg++) begin
      case (seg)
        0: begin wv = 7'd0;   hv = 7'd127; end
        1: begin wv = 7'd127; hv = 7'd0;   end
        2: begin wv = 7'd1;   hv = 7'd1;   end
        3: begin
          wv = CFG_W'($urandom_range(1, 64));
          hv = CFG_W'($urandom_range(1, 64));
        end
        default: begin wv = CFG_W'($urandom_range(0, 127)); hv = 7'd64; end
      endcase
      write_reg(REG_CANVAS_WIDTH, wv);
      write_reg(REG_CANVAS_HEIGHT, hv);
      case (seg)
        0, 1: begin send_idle_pct = 21; recv_idle_pct = 62; end
        2, 3: begin send_idle_pct = 62; recv_idle_pct = 21; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (k = 0; k < LINES_PER_SEG; k++) begin
        send_line(random_line());
        if ($urandom_range(0, 19) == 0) drain_pixels();
      end
      drain_pixels();
    end

    sb.flag_leftover();
    $display("%0d line requests, %0d pixels compared, %0d register writes",
             lines_sent, sb.compared, reg_writes);
    $display("canvas sizes ranged over zero, one, in-range and oversized under three stall mixes");
    if (sb.mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// File: bresenham_line_pixel_gen.f
design/bline_pkg.sv
design/bline_ctrl.sv
design/bline_dp.sv
design/bresenham_line_pixel_gen.sv
test/tb_bresenham_line_pixel_gen.sv
